// ===== hdl/pdmc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdmc_pkg
// Shared types, register indexes and defaults for the PD position controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pdmc_pkg;

    localparam int ANGLE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int GAIN_FRAC      = 8;

    localparam int S_TDATA_W  = 120;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 120;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_TARGET = 2'd1,
        CMD_ENABLE = 2'd2
    } cmd_t;

    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_PROP  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DERIV = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TORQUE_MAX = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TORQUE_MIN = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SLEW_STEP  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DEAD_BAND  = 3'd5;

    localparam logic signed [15:0] GAIN_PROP_RST  = 16'sd1536;
    localparam logic signed [15:0] GAIN_DERIV_RST = -16'sd1536;
    localparam logic [14:0]        TORQUE_MAX_RST = 15'd255;
    localparam logic [14:0]        TORQUE_MIN_RST = 15'd0;
    localparam logic [14:0]        SLEW_STEP_RST  = 15'd31;
    localparam logic [15:0]        DEAD_BAND_RST  = 16'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL_P,
        ST_MUL_D,
        ST_SUM,
        ST_SCALE,
        ST_SLEW,
        ST_CLAMP
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/pdmc_div.sv =====
// ----------------------------------------------------------------------------
// pdmc_div
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
`default_nettype none

module pdmc_div
    import pdmc_pkg::*;
#(
    parameter int DIV_W = ANGLE_BITS_DEF + FRAC_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [31:0]      divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [31:0]      rem_reg,  rem_next;
    logic [DIV_W-1:0] quo_reg,  quo_next;
    logic [31:0]      dvs_reg,  dvs_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [32:0]      trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/pdmc_mul.sv =====
// ----------------------------------------------------------------------------
// pdmc_mul
// Shared signed 16 x 32 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module pdmc_mul
    import pdmc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic signed [15:0] mul_a,
    input  wire logic signed [31:0] mul_b,
    output logic signed [47:0]      mul_p
);

    logic signed [47:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= 48'(mul_a) * 48'(mul_b);
    end

    assign mul_p = prod_reg;

endmodule

`default_nettype wire

// ===== hdl/pd_motor_position_controller.sv =====
// ----------------------------------------------------------------------------
// pd_motor_position_controller
// PD position loop: velocity by serial division, torque from a shared
// multiplier, then slew, minimum and maximum limits.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tuser command, s_tdata tick/target/enable
//  m_        out  m_tvalid/m_tready  m_tdata torque, raw, velocity, flags, count
//  cfg_      in   cfg_we             cfg_addr register index, cfg_wdata value
//
//  target, enable and non-calculating ticks are taken in the idle state
//  a calculating tick runs check, divide, two multiplies, sum, scale, slew and
//  clamp, dividing one bit per cycle; inside the dead band it goes check to clamp
//  s_tready is high only while the sequencer is idle
//  the result register lets the next transfer in; clamp waits while it is full and m_tready is low
//  reset is synchronous, active low, and restores the register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module pd_motor_position_controller
    import pdmc_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // angle_now, time_ms, torque_now, target_angle, enable
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // command
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // torque_out, torque_raw, velocity, slew_limited, raised_to_min,
    // clamped_max, calc_number
    output logic [M_TDATA_W-1:0]       m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int DIV_W = ANGLE_BITS + FRAC_BITS;
    localparam int SHIFT = GAIN_FRAC + FRAC_BITS;
    localparam int SUM_W = (ANGLE_BITS + FRAC_BITS + 16 > 48) ?
                           ANGLE_BITS + FRAC_BITS + 16 : 48;
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'((64'd1 << SHIFT) - 64'd1);
    localparam logic signed [SUM_W-1:0] RAW_HI     = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] RAW_LO     = SUM_W'(-64'sd2147483648);

    // input fields
    logic [1:0]            in_cmd;
    logic [ANGLE_BITS-1:0] in_angle;
    logic [31:0]           in_time;
    logic signed [15:0]    in_torque;
    logic [ANGLE_BITS-1:0] in_target;
    logic                  in_enable;

    assign in_cmd    = s_tuser;
    assign in_angle  = s_tdata[ANGLE_BITS-1:0];
    assign in_time   = s_tdata[63:32];
    assign in_torque = s_tdata[79:64];
    assign in_target = s_tdata[80 +: ANGLE_BITS];
    assign in_enable = s_tdata[112];

    // configuration
    logic signed [15:0] gain_prop_reg, gain_deriv_reg;
    logic [14:0]        torque_max_reg, torque_min_reg, slew_step_reg;
    logic [15:0]        dead_band_reg;

    // controller state
    state_t                state_reg, state_next;
    logic                  is_enabled_reg, is_ready_reg, target_valid_reg;
    logic [ANGLE_BITS-1:0] target_hold_reg, prev_angle_reg;
    logic [31:0]           prev_time_reg, calc_count_reg;

    // working registers
    logic signed [ANGLE_BITS-1:0] err_reg, delta_reg;
    logic [31:0]                  elapsed_reg;
    logic signed [15:0]           last_torque_reg;
    logic                         inband_reg;
    logic signed [31:0]           vel_reg, raw_reg;
    logic signed [47:0]           pprod_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [17:0]           t_reg;
    logic                         slew_flag_reg;

    // result register
    logic        out_valid_reg;
    logic [15:0] out_torque_reg;
    logic [31:0] out_raw_reg, out_vel_reg, out_calc_reg;
    logic        out_slew_reg, out_min_reg, out_max_reg;

    // sequencer outputs
    logic               div_start, out_load;
    logic signed [15:0] mul_a;
    logic signed [31:0] mul_b;

    // datapath nets
    logic                  accept, calc_go;
    logic [ANGLE_BITS-1:0] err_mag, delta_mag;
    logic                  inband_now;
    logic [DIV_W-1:0]      dividend, div_quot;
    logic                  div_busy, div_done;
    logic signed [47:0]    mul_p;
    logic [63:0]           quot_x;
    logic [31:0]           quot_neg, vel_sat;
    logic signed [SUM_W-1:0] bias_sel, sum_biased, sum_scaled;
    logic signed [31:0]    raw_sat;
    logic signed [17:0]    slew_lo, slew_hi, t_slew;
    logic                  slew_hit;
    logic signed [17:0]    min_s, max_s, t_min, t_fin;
    logic                  min_zone, max_hit;

    assign accept  = s_tvalid && s_tready;
    assign calc_go = accept && (in_cmd == CMD_TICK) && is_enabled_reg && is_ready_reg
                     && target_valid_reg && (in_time != prev_time_reg);

    assign err_mag    = err_reg[ANGLE_BITS-1] ? $unsigned(-err_reg) : $unsigned(err_reg);
    assign delta_mag  = delta_reg[ANGLE_BITS-1] ? $unsigned(-delta_reg) : $unsigned(delta_reg);
    assign inband_now = err_mag <= ANGLE_BITS'(dead_band_reg);
    assign dividend   = {delta_mag, {FRAC_BITS{1'b0}}};

    // velocity saturation from the quotient magnitude
    assign quot_x   = 64'(div_quot);
    assign quot_neg = 32'd0 - quot_x[31:0];
    always_comb begin
        if (delta_reg[ANGLE_BITS-1]) begin
            vel_sat = (quot_x > 64'h8000_0000) ? 32'h8000_0000 : quot_neg;
        end else begin
            vel_sat = (quot_x > 64'h7fff_ffff) ? 32'h7fff_ffff : quot_x[31:0];
        end
    end

    // scale by 2^-SHIFT toward zero, then saturate
    assign bias_sel   = sum_reg[SUM_W-1] ? ROUND_BIAS : '0;
    assign sum_biased = sum_reg + bias_sel;
    assign sum_scaled = sum_biased >>> SHIFT;
    assign raw_sat    = (sum_scaled > RAW_HI) ? 32'h7fff_ffff :
                        (sum_scaled < RAW_LO) ? 32'h8000_0000 : sum_scaled[31:0];

    // slew window around the present torque
    assign slew_lo  = 18'(last_torque_reg) - $signed({3'b000, slew_step_reg});
    assign slew_hi  = 18'(last_torque_reg) + $signed({3'b000, slew_step_reg});
    assign slew_hit = (raw_reg < slew_lo) || (raw_reg > slew_hi);
    assign t_slew   = (raw_reg < slew_lo) ? slew_lo :
                      (raw_reg > slew_hi) ? slew_hi : raw_reg[17:0];

    // minimum and maximum magnitude
    assign min_s    = $signed({3'b000, torque_min_reg});
    assign max_s    = $signed({3'b000, torque_max_reg});
    assign min_zone = (t_reg > -min_s) && (t_reg < min_s) && (t_reg != '0);
    assign t_min    = min_zone ? (t_reg[17] ? -min_s : min_s) : t_reg;
    assign max_hit  = (t_min < -max_s) || (t_min > max_s);
    assign t_fin    = (t_min < -max_s) ? -max_s :
                      (t_min > max_s) ? max_s : t_min;

    pdmc_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (elapsed_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    pdmc_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (calc_go) state_next = ST_CHECK;
            ST_CHECK: state_next = inband_now ? ST_CLAMP : ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_MUL_P;
            ST_MUL_P: state_next = ST_MUL_D;
            ST_MUL_D: state_next = ST_SUM;
            ST_SUM:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_SLEW;
            ST_SLEW:  state_next = ST_CLAMP;
            ST_CLAMP: if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        mul_a     = gain_prop_reg;
        mul_b     = 32'(err_reg);
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_CHECK: div_start = !inband_now;
            ST_MUL_D: begin
                mul_a = gain_deriv_reg;
                mul_b = vel_reg;
            end
            ST_CLAMP: out_load = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg  <= GAIN_PROP_RST;
            gain_deriv_reg <= GAIN_DERIV_RST;
            torque_max_reg <= TORQUE_MAX_RST;
            torque_min_reg <= TORQUE_MIN_RST;
            slew_step_reg  <= SLEW_STEP_RST;
            dead_band_reg  <= DEAD_BAND_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_GAIN_PROP:  gain_prop_reg  <= cfg_wdata;
                REG_GAIN_DERIV: gain_deriv_reg <= cfg_wdata;
                REG_TORQUE_MAX: torque_max_reg <= cfg_wdata[14:0];
                REG_TORQUE_MIN: torque_min_reg <= cfg_wdata[14:0];
                REG_SLEW_STEP:  slew_step_reg  <= cfg_wdata[14:0];
                REG_DEAD_BAND:  dead_band_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            is_enabled_reg   <= 1'b0;
            is_ready_reg     <= 1'b0;
            target_valid_reg <= 1'b0;
            calc_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                unique case (in_cmd)
                    CMD_TICK: begin
                        if (is_enabled_reg) is_ready_reg <= 1'b1;
                    end
                    CMD_TARGET: target_valid_reg <= 1'b1;
                    CMD_ENABLE: begin
                        if (in_enable != is_enabled_reg) begin
                            is_enabled_reg   <= in_enable;
                            is_ready_reg     <= 1'b0;
                            target_valid_reg <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            if (calc_go) calc_count_reg <= calc_count_reg + 32'd1;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept && (in_cmd == CMD_TARGET)) target_hold_reg <= in_target;
        if (accept && (in_cmd == CMD_TICK) && is_enabled_reg) begin
            prev_angle_reg <= in_angle;
            prev_time_reg  <= in_time;
        end
        if (calc_go) begin
            err_reg         <= target_hold_reg - in_angle;
            delta_reg       <= in_angle - prev_angle_reg;
            elapsed_reg     <= in_time - prev_time_reg;
            last_torque_reg <= in_torque;
        end
        if (state_reg == ST_CHECK) begin
            inband_reg <= inband_now;
            if (inband_now) begin
                vel_reg       <= '0;
                raw_reg       <= '0;
                t_reg         <= '0;
                slew_flag_reg <= 1'b0;
            end
        end
        if ((state_reg == ST_DIV) && div_done) vel_reg <= vel_sat;
        if (state_reg == ST_MUL_D) pprod_reg <= mul_p;
        if (state_reg == ST_SUM) begin
            sum_reg <= (SUM_W'(pprod_reg) <<< FRAC_BITS) - SUM_W'(mul_p);
        end
        if (state_reg == ST_SCALE) raw_reg <= raw_sat;
        if (state_reg == ST_SLEW) begin
            t_reg         <= t_slew;
            slew_flag_reg <= slew_hit;
        end
        if (out_load) begin
            out_torque_reg <= t_fin[15:0];
            out_raw_reg    <= raw_reg;
            out_vel_reg    <= vel_reg;
            out_slew_reg   <= slew_flag_reg;
            out_min_reg    <= min_zone;
            out_max_reg    <= max_hit;
            out_calc_reg   <= calc_count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_calc_reg, out_max_reg, out_min_reg, out_slew_reg,
                       out_vel_reg, out_raw_reg, out_torque_reg};

    // dead band path never reaches the slew stage
    a_inband_skips_slew: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SLEW) |-> !inband_reg)
        else $error("slew stage entered inside dead band");

    // divider only finishes while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    // the divide state always has a running or finishing divider
    a_div_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (div_busy || div_done))
        else $error("divide state without divider activity");

    // a new result only comes from the clamp stage
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_CLAMP))
        else $error("result raised outside the clamp stage");

endmodule

`default_nettype wire
